// ===== src/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_SAME(lbl, ante, cons, msg)

`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== src/lpd_pkg.sv =====
// types and constants of the length prefix deframer
`timescale 1ns / 1ps

package lpd_pkg;

  localparam int LENGTH_BYTES = 4;
  localparam int LEN_W        = 32;
  localparam int BYTE_W       = 8;
  localparam int KIND_W       = 2;

  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BROKEN  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BADLEN  = 2'd3;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_WATCH_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ONLINE = 1'd1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [KIND_W-1:0] out_kind;
    logic [BYTE_W-1:0] payload_byte;
    logic              last_of_message;
  } lpd_res_t;

  typedef struct packed {
    logic     valid;
    lpd_res_t res;
  } lpd_push_t;

endpackage

// ===== src/lpd_ifs.sv =====
// valid/ready channel interfaces for input and result beats
`timescale 1ns / 1ps

interface lpd_in_if;
  import lpd_pkg::*;
  logic              valid;
  logic              ready;
  logic              action;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, action, rx_byte, input ready);
  modport sink (input valid, action, rx_byte, output ready);
endinterface

interface lpd_out_if;
  import lpd_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] out_kind;
  logic [BYTE_W-1:0] payload_byte;
  logic              last_of_message;
  modport source (output valid, out_kind, payload_byte, last_of_message, input ready);
  modport sink (input valid, out_kind, payload_byte, last_of_message, output ready);
endinterface

// ===== src/lpd_front.sv =====
// front end: accepts beats, tracks framing and heartbeat, classifies results
`timescale 1ns / 1ps

module lpd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  lpd_in_if.sink                        in_ch,
  input  logic                          space,
  input  logic                          cfg_we,
  input  logic [lpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output lpd_pkg::lpd_push_t            push
);
  import lpd_pkg::*;

  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] rcnt_r, rcnt_nxt;
  logic             online_r, online_nxt;
  logic             watch_r, watch_nxt;
  logic             start_r, start_nxt;
  logic             acc;
  logic             in_hdr;
  logic [LEN_W-1:0] len_shift;
  logic [LEN_W-1:0] rcnt_inc;

  assign in_ch.ready = space;
  assign acc         = in_ch.valid && space;
  assign in_hdr      = rcnt_r < LEN_W'(LENGTH_BYTES);
  assign len_shift   = {len_r[LEN_W-BYTE_W-1:0], in_ch.rx_byte};
  assign rcnt_inc    = rcnt_r + LEN_W'(1);

  always_comb begin
    len_nxt    = len_r;
    rcnt_nxt   = rcnt_r;
    online_nxt = online_r;
    watch_nxt  = watch_r;
    start_nxt  = start_r;
    push       = '0;
    if (acc) begin
      if (in_ch.action) begin
        if (watch_r) begin
          if (online_r) begin
            online_nxt = 1'b0;
          end else begin
            push.valid        = 1'b1;
            push.res.out_kind = KIND_BROKEN;
          end
        end
      end else begin
        online_nxt = 1'b1;
        rcnt_nxt   = rcnt_inc;
        if (in_hdr) begin
          len_nxt = len_shift;
          if (rcnt_inc == LEN_W'(LENGTH_BYTES)) begin
            if (len_shift < LEN_W'(LENGTH_BYTES)) begin
              len_nxt           = '0;
              rcnt_nxt          = '0;
              push.valid        = 1'b1;
              push.res.out_kind = KIND_BADLEN;
            end else if (len_shift == LEN_W'(LENGTH_BYTES)) begin
              len_nxt                  = '0;
              rcnt_nxt                 = '0;
              push.valid               = 1'b1;
              push.res.out_kind        = KIND_EMPTY;
              push.res.last_of_message = 1'b1;
            end
          end
        end else begin
          push.valid            = 1'b1;
          push.res.out_kind     = KIND_PAYLOAD;
          push.res.payload_byte = in_ch.rx_byte;
          if (rcnt_inc >= len_r) begin
            len_nxt                  = '0;
            rcnt_nxt                 = '0;
            push.res.last_of_message = 1'b1;
          end
        end
      end
    end
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_WATCH_ENABLE: begin
          watch_nxt = cfg_wdata[0];
          if (cfg_wdata[0]) begin
            online_nxt = start_r;
          end
        end
        CFG_START_ONLINE: begin
          start_nxt = cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      rcnt_r   <= '0;
      online_r <= 1'b0;
      watch_r  <= 1'b0;
      start_r  <= 1'b0;
    end else begin
      len_r    <= len_nxt;
      rcnt_r   <= rcnt_nxt;
      online_r <= online_nxt;
      watch_r  <= watch_nxt;
      start_r  <= start_nxt;
    end
  end

endmodule

// ===== src/lpd_back.sv =====
// back end: result queue that drives the output channel
`timescale 1ns / 1ps

module lpd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  lpd_pkg::lpd_push_t push,
  output logic               space,
  lpd_out_if.source          out_ch
);
  import lpd_pkg::*;

  lpd_res_t            mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0] cnt_r, cnt_nxt;
  logic                pop;
  lpd_res_t            head;

  assign space  = cnt_r != QUEUE_CW'(QUEUE_DEPTH);
  assign pop    = out_ch.valid && out_ch.ready;
  assign head   = mem_r[rd_ptr_r];

  assign out_ch.valid           = cnt_r != '0;
  assign out_ch.out_kind        = head.out_kind;
  assign out_ch.payload_byte    = head.payload_byte;
  assign out_ch.last_of_message = head.last_of_message;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QUEUE_AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QUEUE_AW'(1);
    end
    if (push.valid && !pop) begin
      cnt_nxt = cnt_r + QUEUE_CW'(1);
    end else if (pop && !push.valid) begin
      cnt_nxt = cnt_r - QUEUE_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== src/length_prefix_deframer_heartbeat.sv =====
// top level of the length prefix deframer with heartbeat watch
//
//   port     dir  beat contents
//   in_ch    in   action, rx_byte
//   out_ch   out  out_kind, payload_byte, last_of_message
//   cfg_*    in   cfg_we, cfg_index, cfg_wdata (no handshake)
//
// one input beat per cycle while the queue is not full
// a result is queued as its input beat is taken and reaches out_ch via the queue
// a four-entry queue lets input continue while the output is stalled
// in_ch.ready drops only when the queue is full
// synchronous active-low reset clears framing, heartbeat state and queue pointers
`timescale 1ns / 1ps
`include "assert_macros.svh"

module length_prefix_deframer_heartbeat (
  input  logic                          clk,
  input  logic                          rst_n,
  lpd_in_if.sink                        in_ch,
  lpd_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [lpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lpd_pkg::*;

  lpd_push_t push;
  logic      space;

  lpd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .space     (space),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push      (push)
  );

  lpd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .space  (space),
    .out_ch (out_ch)
  );

  `ASSERT_SAME(a_push_from_beat, push.valid, in_ch.valid && in_ch.ready, "result without input beat")
  `ASSERT_SAME(a_tick_kind, push.valid && in_ch.action, push.res.out_kind == KIND_BROKEN, "tick gave wrong kind")
  `ASSERT_SAME(a_zero_byte, push.valid && push.res.out_kind != KIND_PAYLOAD, push.res.payload_byte == '0, "nonzero byte on non-payload")
  `ASSERT_NEXT(a_out_after_push, push.valid, out_ch.valid, "queued result not shown")
  `ASSERT_SAME(a_ready_when_empty, !out_ch.valid, in_ch.ready, "empty queue refused input")

endmodule
